/* src/quoted_token_extractor_macros.svh */
// ----------------------------------------------------------------------------
// Quoted token extractor assertion macros
// Shared property wrappers for the checker of the token extractor.
// ----------------------------------------------------------------------------
`ifndef QUOTED_TOKEN_EXTRACTOR_MACROS_SVH
`define QUOTED_TOKEN_EXTRACTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QTE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("quoted token extractor assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define QTE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("quoted token extractor assertion failed");

`endif

/* src/qte_pkg.sv */
// ----------------------------------------------------------------------------
// Quoted token extractor package
// Status codes, character codes and stream widths of the token extractor.
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int MAX_TOKEN_LEN_DEFAULT = 256;

    localparam int CHAR_W    = 8;
    localparam int LENGTH_W  = 9;
    localparam int STATUS_W  = 3;
    localparam int IN_DATA_W = 8;
    localparam int OUT_DATA_W = ((CHAR_W + LENGTH_W + 7) / 8) * 8;

    typedef enum logic [STATUS_W-1:0] {
        ST_BYTE      = 3'd0,
        ST_DONE      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_EARLY_END = 3'd3,
        ST_TOO_LONG  = 3'd4
    } status_t;

    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [CHAR_W-1:0] CH_N      = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_T      = 8'h74;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

endpackage

/* src/quoted_token_extractor.sv */
// ----------------------------------------------------------------------------
// Quoted token extractor
// Splits a byte stream into blank-separated tokens with quoting and escapes.
// ----------------------------------------------------------------------------
// One byte enters per transfer on the slave stream; tuser set marks the end
// of the input and the byte is then ignored. Each accepted byte gives zero or
// one result on the master stream: a token byte (status 0, tlast low) or the
// end result of a token (status 1 to 4, tlast high, token length in tdata).
// A double quote at the start of a token opens quoted mode, a backslash
// escapes the next byte, and a blank outside quoted mode ends the token.
// The result of an input transfer is registered in the output register for the
// following cycle. The block takes one byte every cycle; the single output register
// is refilled in the same cycle in which its result is taken, so the slave
// side stalls only while a result waits and the receiver holds tready low.
// Reset empties the output register and returns the parser to the state of
// no token begun.
// ----------------------------------------------------------------------------
module quoted_token_extractor #(
    parameter int MAX_TOKEN_LEN = qte_pkg::MAX_TOKEN_LEN_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [7:0] char_in
    input  logic [qte_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [0] end_of_input
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] out_char, [16:8] token_length, upper bits zero
    output logic [qte_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // [2:0] status
    output logic [qte_pkg::STATUS_W-1:0]    m_axis_tuser,
    // token_last
    output logic                            m_axis_tlast
);

    localparam int CNT_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam int PAD_W = qte_pkg::OUT_DATA_W - qte_pkg::CHAR_W - qte_pkg::LENGTH_W;

    typedef enum logic [1:0] {
        MODE_PLAIN,
        MODE_QUOTED,
        MODE_SKIP
    } mode_t;

    mode_t                          mode_reg, mode_next;
    logic                           esc_reg, esc_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic                           ovf_reg, ovf_next;
    logic                           valid_reg, valid_next;
    logic [qte_pkg::CHAR_W-1:0]     char_reg, char_next;
    qte_pkg::status_t               status_reg, status_next;
    logic [qte_pkg::LENGTH_W-1:0]   length_reg, length_next;
    logic                           last_reg, last_next;

    logic                           accept;
    logic [qte_pkg::CHAR_W-1:0]     c;
    logic [qte_pkg::CHAR_W-1:0]     c_xlat;
    logic                           blank;
    qte_pkg::status_t               normal_status;
    logic                           emit_end;
    logic                           emit_byte;
    qte_pkg::status_t               end_status;

    assign s_axis_tready = !valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign c             = s_axis_tdata[qte_pkg::CHAR_W-1:0];
    assign blank         = qte_pkg::is_blank(c);

    always_comb
    begin
        if (ovf_reg)
        begin
            normal_status = qte_pkg::ST_TOO_LONG;
        end
        else if (count_reg != '0)
        begin
            normal_status = qte_pkg::ST_DONE;
        end
        else
        begin
            normal_status = qte_pkg::ST_EMPTY;
        end
    end

    always_comb
    begin
        if (esc_reg && (c == qte_pkg::CH_N))
        begin
            c_xlat = qte_pkg::CH_LF;
        end
        else if (esc_reg && (c == qte_pkg::CH_T))
        begin
            c_xlat = qte_pkg::CH_TAB;
        end
        else
        begin
            c_xlat = c;
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        esc_next   = esc_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        emit_end   = 1'b0;
        emit_byte  = 1'b0;
        end_status = normal_status;

        if (accept)
        begin
            priority if (s_axis_tuser)
            begin
                emit_end   = 1'b1;
                end_status = qte_pkg::ST_EARLY_END;
            end
            else if (mode_reg == MODE_SKIP)
            begin
                emit_end = blank;
            end
            else if ((mode_reg != MODE_QUOTED) && blank)
            begin
                emit_end = 1'b1;
            end
            else if (!esc_reg && (c == qte_pkg::CH_BSLASH))
            begin
                esc_next = 1'b1;
            end
            else if (!esc_reg && (c == qte_pkg::CH_QUOTE) && (mode_reg == MODE_QUOTED))
            begin
                mode_next = MODE_SKIP;
            end
            else if (!esc_reg && (c == qte_pkg::CH_QUOTE) && (count_reg == '0) && !ovf_reg)
            begin
                mode_next = MODE_QUOTED;
            end
            else
            begin
                esc_next = 1'b0;
                if (!ovf_reg)
                begin
                    if (count_reg >= CNT_W'(MAX_TOKEN_LEN))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        emit_byte  = 1'b1;
                    end
                end
            end

            if (!s_axis_tuser && (c == qte_pkg::CH_QUOTE) && !esc_reg
                && (mode_reg != MODE_SKIP) && !((mode_reg != MODE_QUOTED) && blank))
            begin
                esc_next = 1'b0;
            end

            if (emit_end)
            begin
                mode_next  = MODE_PLAIN;
                esc_next   = 1'b0;
                count_next = '0;
                ovf_next   = 1'b0;
            end
        end
    end

    always_comb
    begin
        valid_next  = valid_reg && !m_axis_tready;
        char_next   = char_reg;
        status_next = status_reg;
        length_next = length_reg;
        last_next   = last_reg;

        if (emit_end)
        begin
            valid_next  = 1'b1;
            char_next   = '0;
            status_next = end_status;
            length_next = qte_pkg::LENGTH_W'(count_reg);
            last_next   = 1'b1;
        end
        else if (emit_byte)
        begin
            valid_next  = 1'b1;
            char_next   = c_xlat;
            status_next = qte_pkg::ST_BYTE;
            length_next = '0;
            last_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_PLAIN;
            esc_reg    <= 1'b0;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            valid_reg  <= 1'b0;
            char_reg   <= '0;
            status_reg <= qte_pkg::ST_BYTE;
            length_reg <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            esc_reg    <= esc_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            valid_reg  <= valid_next;
            char_reg   <= char_next;
            status_reg <= status_next;
            length_reg <= length_next;
            last_reg   <= last_next;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, length_reg, char_reg};
    assign m_axis_tuser  = status_reg;
    assign m_axis_tlast  = last_reg;

endmodule

/* src/qte_checker.sv */
// ----------------------------------------------------------------------------
// Quoted token extractor checker
// Port-level assertions on the result stream and input ready of the token extractor.
// ----------------------------------------------------------------------------
`include "quoted_token_extractor_macros.svh"

module qte_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tready,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [qte_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic [qte_pkg::STATUS_W-1:0]    m_axis_tuser,
    input  logic                            m_axis_tlast
);

    `QTE_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
        && $stable(m_axis_tlast))
    `QTE_ASSERT_SAME(a_last_status, m_axis_tvalid,
        m_axis_tlast == (m_axis_tuser != qte_pkg::ST_BYTE))
    `QTE_ASSERT_SAME(a_byte_no_len, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[16:8] == '0)
    `QTE_ASSERT_SAME(a_end_no_char, m_axis_tvalid && m_axis_tlast, m_axis_tdata[7:0] == '0)
    `QTE_ASSERT_SAME(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)

endmodule

bind quoted_token_extractor qte_checker u_qte_checker (.*);

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quoted token extractor testbench
// Streams directed and random text through the extractor with random bursts,
// gaps and output stalls, predicts every token byte and end-of-token transfer
// in the bench, and compares each output transfer field by field in order.
// ----------------------------------------------------------------------------
module testbench;

    import qte_pkg::*;

    localparam int TOKEN_LIMIT   = MAX_TOKEN_LEN_DEFAULT;
    localparam int RANDOM_ITEMS  = 1900;
    localparam int IDLE_LIMIT    = 2000;
    localparam int HOLD_AFTER    = 400;
    localparam int HOLD_CYCLES   = 300;

    typedef enum logic [1:0] {
        PARSE_PLAIN,
        PARSE_QUOTED,
        PARSE_SKIP
    } parse_mode_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              eoi;
    } text_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0]   ch;
        status_t             status;
        logic [LENGTH_W-1:0] tok_len;
        logic                tok_last;
    } token_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;
    logic                  m_axis_tlast;

    text_item_t    pending_text[$];
    token_result_t expected_results[$];
    int            errors = 0;

    parse_mode_t   tok_mode = PARSE_PLAIN;
    logic          tok_escaped = 1'b0;
    int            tok_count = 0;
    logic          tok_overflow = 1'b0;

    text_item_t    cur_item;
    token_result_t cur_result;
    int            burst_left = 0;
    int            gap_left = 0;
    int            items_taken = 0;

    int            seg_left;
    int            seg_kind;
    int            hold_left;
    logic          hold_done;
    int            idle_cycles = 0;

    always #5 clk = ~clk;

    quoted_token_extractor #(
        .MAX_TOKEN_LEN(TOKEN_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    function automatic logic is_separator(input logic [CHAR_W-1:0] c);
        case (c)
            CH_SPACE, CH_TAB, CH_LF, CH_CR: return 1'b1;
            default:                        return 1'b0;
        endcase
    endfunction

    function automatic logic tokenize(input text_item_t it, output token_result_t r);
        logic [CHAR_W-1:0] c;
        logic              was_escaped;
        logic              ends;
        status_t           st;
        c = it.ch;
        ends = 1'b0;
        st = ST_BYTE;
        r.ch = '0;
        r.status = ST_BYTE;
        r.tok_len = '0;
        r.tok_last = 1'b0;
        if (it.eoi)
        begin
            ends = 1'b1;
            st = ST_EARLY_END;
        end
        else if (tok_mode != PARSE_QUOTED && is_separator(c))
        begin
            ends = 1'b1;
            if (tok_overflow)
                st = ST_TOO_LONG;
            else
                st = (tok_count != 0) ? ST_DONE : ST_EMPTY;
        end
        if (ends)
        begin
            r.status = st;
            r.tok_len = tok_count[LENGTH_W-1:0];
            r.tok_last = 1'b1;
            tok_mode = PARSE_PLAIN;
            tok_escaped = 1'b0;
            tok_count = 0;
            tok_overflow = 1'b0;
            return 1'b1;
        end
        if (tok_mode == PARSE_SKIP)
            return 1'b0;
        if (!tok_escaped && c == CH_BSLASH)
        begin
            tok_escaped = 1'b1;
            return 1'b0;
        end
        was_escaped = tok_escaped;
        tok_escaped = 1'b0;
        if (was_escaped)
        begin
            if (c == CH_N)
                c = CH_LF;
            else if (c == CH_T)
                c = CH_TAB;
        end
        else if (c == CH_QUOTE)
        begin
            if (tok_mode == PARSE_QUOTED)
            begin
                tok_mode = PARSE_SKIP;
                return 1'b0;
            end
            if (tok_count == 0 && !tok_overflow)
            begin
                tok_mode = PARSE_QUOTED;
                return 1'b0;
            end
        end
        if (tok_overflow)
            return 1'b0;
        if (tok_count >= TOKEN_LIMIT)
        begin
            tok_overflow = 1'b1;
            return 1'b0;
        end
        tok_count++;
        r.ch = c;
        return 1'b1;
    endfunction

    task automatic add_byte(input logic [CHAR_W-1:0] c);
        text_item_t it;
        it.ch = c;
        it.eoi = 1'b0;
        pending_text.push_back(it);
    endtask

    task automatic add_end();
        text_item_t it;
        it.ch = CHAR_W'($urandom_range(0, 255));
        it.eoi = 1'b1;
        pending_text.push_back(it);
    endtask

    task automatic add_terminator();
        if ($urandom_range(0, 99) < 12)
            add_end();
        else
            case ($urandom_range(0, 3))
                0: add_byte(CH_SPACE);
                1: add_byte(CH_TAB);
                2: add_byte(CH_LF);
                default: add_byte(CH_CR);
            endcase
    endtask

    task automatic add_escape();
        add_byte(CH_BSLASH);
        case ($urandom_range(0, 5))
            0: add_byte(CH_N);
            1: add_byte(CH_T);
            2: add_byte(CH_BSLASH);
            3: add_byte(CH_QUOTE);
            4: add_byte(CH_SPACE);
            default: add_byte(CHAR_W'($urandom_range(0, 255)));
        endcase
    endtask

    function automatic logic [CHAR_W-1:0] word_byte();
        logic [CHAR_W-1:0] c;
        c = CHAR_W'($urandom_range(0, 255));
        if (is_separator(c))
            c = c | 8'h40;
        return c;
    endfunction

    task automatic add_plain_token();
        int n;
        int r;
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
                add_escape();
            else if (r < 16)
                add_byte(CH_QUOTE);
            else
                add_byte(word_byte());
        end
        add_terminator();
    endtask

    task automatic add_quoted_token();
        int n;
        int r;
        add_byte(CH_QUOTE);
        n = $urandom_range(0, 14);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                add_escape();
            else if (r < 18)
                add_byte(($urandom_range(0, 1) == 0) ? CH_SPACE : CH_TAB);
            else
                add_byte(CHAR_W'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 99) < 80)
        begin
            add_byte(CH_QUOTE);
            if ($urandom_range(0, 99) < 30)
                repeat ($urandom_range(1, 3)) add_byte(word_byte());
            add_terminator();
        end
        else
            add_end();
    endtask

    task automatic add_long_token(input int n, input logic quoted);
        logic [CHAR_W-1:0] c;
        if (quoted)
            add_byte(CH_QUOTE);
        for (int i = 0; i < n; i++)
        begin
            c = word_byte();
            if (c == CH_BSLASH || c == CH_QUOTE)
                c = CH_N;
            add_byte(c);
        end
        if (quoted)
            add_byte(CH_QUOTE);
        add_byte(CH_SPACE);
    endtask

    task automatic note_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            errors++;
        end
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= 1'b0;
            items_taken <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                items_taken <= items_taken + 1;
                if (tokenize(cur_item, cur_result))
                    expected_results.push_back(cur_result);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_text.size() == 0)
                    s_axis_tvalid <= 1'b0;
                else
                begin
                    cur_item = pending_text.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= cur_item.ch;
                    s_axis_tuser <= cur_item.eoi;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // Receiver: stall pattern in segments, plus one long hold to back up the input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            seg_left <= 0;
            seg_kind <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && items_taken >= HOLD_AFTER)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (seg_left == 0)
            begin
                seg_kind <= $urandom_range(0, 3);
                seg_left <= $urandom_range(5, 80);
            end
            else
                seg_left <= seg_left - 1;
            case (seg_kind)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= ($urandom_range(0, 7) != 0);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        token_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none, %s %0h tuser %0d tlast %b",
                         $time, "actual tdata", m_axis_tdata, m_axis_tuser, m_axis_tlast);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                note_mismatch("out_char", 32'(want.ch), 32'(m_axis_tdata[CHAR_W-1:0]));
                note_mismatch("token_length", 32'(want.tok_len),
                              32'(m_axis_tdata[CHAR_W+LENGTH_W-1:CHAR_W]));
                note_mismatch("tdata padding", 0,
                              32'(m_axis_tdata[OUT_DATA_W-1:CHAR_W+LENGTH_W]));
                note_mismatch("status", 32'(want.status), 32'(m_axis_tuser));
                note_mismatch("token_last", 32'(want.tok_last), 32'(m_axis_tlast));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int directed;
        int r;

        // End of input before any byte, then a token of only a leading blank.
        add_end();
        add_byte(CH_SPACE);
        // Extreme byte values and a quote inside a plain token.
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(CH_QUOTE);
        add_byte(CH_TAB);
        // Empty quotes.
        add_byte(CH_QUOTE);
        add_byte(CH_QUOTE);
        add_byte(CH_CR);
        // An escaped blank still ends a plain token.
        add_byte("a");
        add_byte(CH_BSLASH);
        add_byte(CH_SPACE);
        // An escaped backslash leaves the next byte unescaped.
        add_byte(CH_BSLASH);
        add_byte(CH_BSLASH);
        add_byte(CH_N);
        add_byte(CH_LF);
        // Quoted token with escapes, then junk after the closing quote and end of input.
        add_byte(CH_QUOTE);
        add_byte(CH_BSLASH);
        add_byte(CH_N);
        add_byte(CH_BSLASH);
        add_byte(CH_T);
        add_byte(CH_SPACE);
        add_byte(CH_BSLASH);
        add_byte(CH_QUOTE);
        add_byte(CH_QUOTE);
        add_byte("z");
        add_end();
        directed = pending_text.size();

        // Exactly full, one byte over, and a quoted token well past the limit.
        add_long_token(TOKEN_LIMIT, 1'b0);
        add_long_token(TOKEN_LIMIT + 1, 1'b0);
        add_long_token($urandom_range(TOKEN_LIMIT + 2, TOKEN_LIMIT + 40), 1'b1);

        while (pending_text.size() < directed + RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                add_plain_token();
            else if (r < 80)
                add_quoted_token();
            else if (r < 95)
            begin
                repeat ($urandom_range(1, 8)) add_byte(CHAR_W'($urandom_range(0, 255)));
                if ($urandom_range(0, 99) < 3)
                    add_end();
            end
            else
                add_terminator();
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (pending_text.size() != 0 || s_axis_tvalid);
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
